/* design/rms_bar_level_meter_unit_assert.svh */
// Assertion helpers shared by the meter RTL.
`ifndef RMS_BAR_LEVEL_METER_UNIT_ASSERT_SVH
`define RMS_BAR_LEVEL_METER_UNIT_ASSERT_SVH

// Check a property in the same cycle as its trigger.
`define RBM_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Check a property in the cycle after its trigger.
`define RBM_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

/* design/rbm_pkg.sv */
package rbm_pkg;

   // Default geometry of the meter
   localparam int COLUMNS_DEF    = 32;
   localparam int HEIGHT_MAX_DEF = 128;
   localparam int MAX_GROUP_DEF  = 4096;

   // Fixed field widths
   localparam int SAMPLE_W    = 16;
   localparam int SQUARE_W    = 31;
   localparam int FS_W        = 16;
   localparam int SPB_W       = 13;
   localparam int DECAY_W     = 8;
   localparam int COLUMN_W    = 5;
   localparam int HEIGHT_W    = 8;
   localparam int LEVEL_W     = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;

   // Shared multiplier slices the wide operand into chunks of this width
   localparam int CHUNK_W     = 16;
   localparam int CHUNK_CNT_W = 3;

   // Level thresholds in percent of full height
   localparam int PCT_SCALE = 100;
   localparam int PCT_HIGH  = 80;
   localparam int PCT_MID   = 50;
   localparam int PCT_W     = 16;

   // Register reset values
   localparam logic [SPB_W-1:0]   SPB_RESET   = 13'd1;
   localparam logic [FS_W-1:0]    FS_RESET    = 16'd1024;
   localparam logic [DECAY_W-1:0] DECAY_RESET = 8'd2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_SAMPLES_PER_BAR = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FULL_SCALE      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DECAY_STEP      = 2'd2;

   // Level class codes
   localparam logic [LEVEL_W-1:0] LEVEL_LOW  = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_MID  = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_HIGH = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_WAIT,
      ST_FS2,
      ST_FS2_WAIT,
      ST_FSN_WAIT,
      ST_RHS_WAIT,
      ST_TRY,
      ST_TSQ_WAIT,
      ST_LHS_WAIT,
      ST_SMOOTH,
      ST_OUT
   } rbm_state_type;

   typedef struct packed {
      logic                   start;
      logic [CHUNK_CNT_W-1:0] chunks;
   } mac_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mac_sts_type;

   typedef struct packed {
      logic clear;
      logic rd_en;
      logic wr_en;
   } bar_ctl_type;

endpackage

/* design/rms_bar_level_meter_unit.sv */
// Each sample is accepted, then multiplied and folded on the shared MAC and added to the sum;
// req_ready stays low until that is done. A group's last sample also runs the height search
// on the MAC: fs^2, fs^2*n, sum*H^2, then per height bit trial^2 and trial^2*fs^2*n (skipped
// when the trial is above HEIGHT_MAX); the response is registered once the output is free, then input opens again.
// Synchronous reset restores register defaults, zeroes counters and sum and drops all bar
// heights at once through per-column valid bits; no clearing pass follows.
`include "rms_bar_level_meter_unit_assert.svh"

module rms_bar_level_meter_unit
   import rbm_pkg::*;
#(
   parameter int COLUMNS    = COLUMNS_DEF,
   parameter int HEIGHT_MAX = HEIGHT_MAX_DEF,
   parameter int MAX_GROUP  = MAX_GROUP_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_mode,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [COLUMN_W-1:0]        rsp_column,
   output logic [HEIGHT_W-1:0]        rsp_bar_height,
   output logic [LEVEL_W-1:0]         rsp_level_class,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   localparam int H_W    = $clog2(HEIGHT_MAX + 1);
   localparam int BIT_W  = (H_W > 1) ? $clog2(H_W) : 1;
   localparam int N_W    = $clog2(MAX_GROUP + 1);
   localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int SUM_W  = SQUARE_W + $clog2(MAX_GROUP);
   localparam int FSN_W  = 2 * FS_W + N_W;
   localparam int B_W    = (N_W > CHUNK_W) ? N_W : CHUNK_W;
   localparam int FSN_C  = (FSN_W + CHUNK_W - 1) / CHUNK_W;
   localparam int SUM_C  = (SUM_W + CHUNK_W - 1) / CHUNK_W;
   localparam int MAX_C  = (FSN_C > SUM_C) ? FSN_C : SUM_C;
   localparam int OP_W   = CHUNK_W * MAX_C;
   localparam int ACC_W  = OP_W + B_W;
   localparam int SH_ONE = CHUNK_W * (MAX_C - 1);
   localparam int SH_TWO = CHUNK_W * (MAX_C - 2);
   localparam int SH_FSN = CHUNK_W * (MAX_C - FSN_C);
   localparam int SH_SUM = CHUNK_W * (MAX_C - SUM_C);
   localparam int HSQ    = HEIGHT_MAX * HEIGHT_MAX;
   localparam int LVL_HI = (PCT_HIGH + 1) * HEIGHT_MAX;
   localparam int LVL_MD = (PCT_MID + 1) * HEIGHT_MAX;

   rbm_state_type        state_ff, state_in;
   logic [SPB_W-1:0]     spb_ff, spb_in;
   logic [FS_W-1:0]      fs_ff, fs_in;
   logic [DECAY_W-1:0]   decay_ff, decay_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [N_W-1:0]       cnt_ff, cnt_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [FSN_W-1:0]     fsn_ff, fsn_in;
   logic [ACC_W-1:0]     rhs_ff, rhs_in;
   logic [H_W-1:0]       h_ff, h_in;
   logic [BIT_W-1:0]     bit_ff, bit_in;
   logic [H_W-1:0]       hgt_ff, hgt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COLUMN_W-1:0]  rsp_column_ff, rsp_column_in;
   logic [HEIGHT_W-1:0]  rsp_height_ff, rsp_height_in;
   logic [LEVEL_W-1:0]   rsp_level_ff, rsp_level_in;

   mac_ctl_type          mac_ctl;
   mac_sts_type          mac_sts;
   logic [OP_W-1:0]      mac_operand;
   logic [B_W-1:0]       mac_mult;
   logic [ACC_W-1:0]     mac_acc;
   bar_ctl_type          bar_ctl;
   logic [H_W-1:0]       bar_rd_data;

   logic [SAMPLE_W-1:0]  mag;
   logic [FS_W-1:0]      fs_eff;
   logic [N_W-1:0]       grp_len;
   logic [N_W-1:0]       cnt_next;
   logic                 grp_end;
   logic [H_W-1:0]       trial;
   logic                 trial_fits;
   logic                 lhs_fits;
   logic                 last_bit;
   logic [DECAY_W-1:0]   cur_ext;
   logic [H_W-1:0]       smoothed;
   logic                 out_free;
   logic [PCT_W-1:0]     pct_num;
   logic [LEVEL_W-1:0]   level;
   logic [COL_W-1:0]     col_wrap;

   // Operand conditioning
   always_comb begin
      mag    = req_sample[SAMPLE_W-1] ? (~req_sample + 1'b1) : req_sample;
      fs_eff = (fs_ff == '0) ? FS_W'(1) : fs_ff;
      if (spb_ff == '0) begin
         grp_len = N_W'(1);
      end else if (32'(spb_ff) > 32'(MAX_GROUP)) begin
         grp_len = N_W'(MAX_GROUP);
      end else begin
         grp_len = N_W'(spb_ff);
      end
      cnt_next   = cnt_ff + 1'b1;
      grp_end    = (cnt_next >= grp_len);
      trial      = h_ff | (H_W'(1) << bit_ff);
      trial_fits = (trial <= H_W'(HEIGHT_MAX));
      lhs_fits   = (mac_acc <= rhs_ff);
      last_bit   = (bit_ff == '0);
      out_free   = !rsp_valid_ff || rsp_ready;
      col_wrap   = (col_ff == COL_W'(COLUMNS - 1)) ? '0 : col_ff + 1'b1;
   end

   // Fast rise, slow decay floored at zero
   always_comb begin
      cur_ext = DECAY_W'(bar_rd_data);
      if (h_ff >= bar_rd_data) begin
         smoothed = h_ff;
      end else if (cur_ext > decay_ff) begin
         smoothed = H_W'(cur_ext - decay_ff);
      end else begin
         smoothed = '0;
      end
   end

   // Level class from percent thresholds, without a divider
   always_comb begin
      pct_num = PCT_W'(hgt_ff) * PCT_W'(PCT_SCALE);
      if (pct_num >= PCT_W'(LVL_HI)) begin
         level = LEVEL_HIGH;
      end else if (pct_num >= PCT_W'(LVL_MD)) begin
         level = LEVEL_MID;
      end else begin
         level = LEVEL_LOW;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_mode) begin
               state_in = ST_SQ_WAIT;
            end
         end
         ST_SQ_WAIT: begin
            if (mac_sts.done) begin
               state_in = grp_end ? ST_FS2 : ST_IDLE;
            end
         end
         ST_FS2: state_in = ST_FS2_WAIT;
         ST_FS2_WAIT: begin
            if (mac_sts.done) begin
               state_in = ST_FSN_WAIT;
            end
         end
         ST_FSN_WAIT: begin
            if (mac_sts.done) begin
               state_in = ST_RHS_WAIT;
            end
         end
         ST_RHS_WAIT: begin
            if (mac_sts.done) begin
               state_in = ST_TRY;
            end
         end
         ST_TRY: begin
            if (trial_fits) begin
               state_in = ST_TSQ_WAIT;
            end else if (last_bit) begin
               state_in = ST_SMOOTH;
            end
         end
         ST_TSQ_WAIT: begin
            if (mac_sts.done) begin
               state_in = ST_LHS_WAIT;
            end
         end
         ST_LHS_WAIT: begin
            if (mac_sts.done) begin
               state_in = last_bit ? ST_SMOOTH : ST_TRY;
            end
         end
         ST_SMOOTH: state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: MAC commands, bar memory strobes, ready
   always_comb begin
      req_ready      = 1'b0;
      mac_ctl.start  = 1'b0;
      mac_ctl.chunks = CHUNK_CNT_W'(1);
      mac_operand    = OP_W'(mag) << SH_ONE;
      mac_mult       = B_W'(mag);
      bar_ctl        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready      = 1'b1;
            mac_ctl.start  = req_valid && !req_mode;
            bar_ctl.clear  = req_valid && req_mode;
         end
         ST_FS2: begin
            mac_ctl.start = 1'b1;
            mac_operand   = OP_W'(fs_eff) << SH_ONE;
            mac_mult      = B_W'(fs_eff);
            bar_ctl.rd_en = 1'b1;
         end
         ST_FS2_WAIT: begin
            mac_ctl.start  = mac_sts.done;
            mac_ctl.chunks = CHUNK_CNT_W'(2);
            mac_operand    = OP_W'(mac_acc[2*FS_W-1:0]) << SH_TWO;
            mac_mult       = B_W'(grp_len);
         end
         ST_FSN_WAIT: begin
            mac_ctl.start  = mac_sts.done;
            mac_ctl.chunks = CHUNK_CNT_W'(SUM_C);
            mac_operand    = OP_W'(sum_ff) << SH_SUM;
            mac_mult       = B_W'(HSQ);
         end
         ST_TRY: begin
            mac_ctl.start = trial_fits;
            mac_operand   = OP_W'(trial) << SH_ONE;
            mac_mult      = B_W'(trial);
         end
         ST_TSQ_WAIT: begin
            mac_ctl.start  = mac_sts.done;
            mac_ctl.chunks = CHUNK_CNT_W'(FSN_C);
            mac_operand    = OP_W'(fsn_ff) << SH_FSN;
            mac_mult       = B_W'(mac_acc[2*H_W-1:0]);
         end
         ST_SMOOTH: begin
            bar_ctl.wr_en = 1'b1;
         end
         default: ;
      endcase
   end

   // Datapath registers
   always_comb begin
      spb_in        = spb_ff;
      fs_in         = fs_ff;
      decay_in      = decay_ff;
      col_in        = col_ff;
      cnt_in        = cnt_ff;
      sum_in        = sum_ff;
      fsn_in        = fsn_ff;
      rhs_in        = rhs_ff;
      h_in          = h_ff;
      bit_in        = bit_ff;
      hgt_in        = hgt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_column_in = rsp_column_ff;
      rsp_height_in = rsp_height_ff;
      rsp_level_in  = rsp_level_ff;

      // Configuration writes
      if (csr_we) begin
         case (csr_index)
            REG_SAMPLES_PER_BAR: spb_in   = csr_wdata[SPB_W-1:0];
            REG_FULL_SCALE:      fs_in    = csr_wdata[FS_W-1:0];
            REG_DECAY_STEP:      decay_in = csr_wdata[DECAY_W-1:0];
            default: ;
         endcase
      end

      // Release the response once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_mode) begin
               col_in = '0;
               cnt_in = '0;
               sum_in = '0;
            end
         end
         ST_SQ_WAIT: begin
            if (mac_sts.done) begin
               sum_in = sum_ff + SUM_W'(mac_acc[SQUARE_W-1:0]);
               cnt_in = cnt_next;
            end
         end
         ST_FSN_WAIT: begin
            if (mac_sts.done) begin
               fsn_in = mac_acc[FSN_W-1:0];
            end
         end
         ST_RHS_WAIT: begin
            if (mac_sts.done) begin
               rhs_in = mac_acc;
               h_in   = '0;
               bit_in = BIT_W'(H_W - 1);
            end
         end
         ST_TRY: begin
            if (!trial_fits && !last_bit) begin
               bit_in = bit_ff - 1'b1;
            end
         end
         ST_LHS_WAIT: begin
            if (mac_sts.done) begin
               if (lhs_fits) begin
                  h_in = trial;
               end
               if (!last_bit) begin
                  bit_in = bit_ff - 1'b1;
               end
            end
         end
         ST_SMOOTH: begin
            hgt_in = smoothed;
            cnt_in = '0;
            sum_in = '0;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_column_in = COLUMN_W'(col_ff);
               rsp_height_in = HEIGHT_W'(hgt_ff);
               rsp_level_in  = level;
               col_in        = col_wrap;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         spb_ff       <= SPB_RESET;
         fs_ff        <= FS_RESET;
         decay_ff     <= DECAY_RESET;
         col_ff       <= '0;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         spb_ff       <= spb_in;
         fs_ff        <= fs_in;
         decay_ff     <= decay_in;
         col_ff       <= col_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fsn_ff        <= fsn_in;
      rhs_ff        <= rhs_in;
      h_ff          <= h_in;
      bit_ff        <= bit_in;
      hgt_ff        <= hgt_in;
      rsp_column_ff <= rsp_column_in;
      rsp_height_ff <= rsp_height_in;
      rsp_level_ff  <= rsp_level_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_column      = rsp_column_ff;
   assign rsp_bar_height  = rsp_height_ff;
   assign rsp_level_class = rsp_level_ff;

   // Shared multiply-accumulate unit
   rbm_mac #(
      .OP_W  (OP_W),
      .B_W   (B_W),
      .ACC_W (ACC_W)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mac_ctl),
      .operand (mac_operand),
      .mult    (mac_mult),
      .sts     (mac_sts),
      .acc     (mac_acc)
   );

   // Stored column heights
   rbm_bar_mem #(
      .DEPTH  (COLUMNS),
      .ADDR_W (COL_W),
      .DATA_W (H_W)
   ) u_bar_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (bar_ctl),
      .rd_addr (col_ff),
      .wr_addr (col_ff),
      .wr_data (smoothed),
      .rd_data (bar_rd_data)
   );

   `RBM_ASSERT_NEXT(a_sample_starts_mac, clock, reset, req_valid && req_ready && !req_mode, mac_sts.busy, "sample accepted without a MAC pass")
   `RBM_ASSERT_NEXT(a_clear_restarts, clock, reset, req_valid && req_ready && req_mode, cnt_ff == '0 && col_ff == '0 && sum_ff == '0, "clear did not restart the frame")
   `RBM_ASSERT_NOW(a_done_in_wait, clock, reset, mac_sts.done, state_ff == ST_SQ_WAIT || state_ff == ST_FS2_WAIT || state_ff == ST_FSN_WAIT || state_ff == ST_RHS_WAIT || state_ff == ST_TSQ_WAIT || state_ff == ST_LHS_WAIT, "MAC finished outside a wait state")
   `RBM_ASSERT_NOW(a_height_bounded, clock, reset, state_ff == ST_SMOOTH, h_ff <= H_W'(HEIGHT_MAX), "search gave a height above full scale")
   `RBM_ASSERT_NOW(a_rsp_height_bounded, clock, reset, rsp_valid, rsp_bar_height <= HEIGHT_W'(HEIGHT_MAX), "response height above full scale")

endmodule

/* design/rbm_mac.sv */
module rbm_mac
   import rbm_pkg::*;
#(
   parameter int OP_W  = 48,
   parameter int B_W   = 16,
   parameter int ACC_W = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  mac_ctl_type       ctl,
   input  logic [OP_W-1:0]   operand,
   input  logic [B_W-1:0]    mult,
   output mac_sts_type       sts,
   output logic [ACC_W-1:0]  acc
);

   localparam int PROD_W = CHUNK_W + B_W;

   logic [OP_W-1:0]        op_ff, op_in;
   logic [B_W-1:0]         mult_ff, mult_in;
   logic [CHUNK_CNT_W-1:0] left_ff, left_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic                   prod_vld_ff, prod_vld_in;
   logic                   first_ff, first_in;
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic                   done_ff, done_in;

   // Issue one chunk per cycle, top chunk first, and fold in Horner order
   always_comb begin
      op_in       = op_ff;
      mult_in     = mult_ff;
      left_in     = left_ff;
      prod_in     = prod_ff;
      prod_vld_in = 1'b0;
      first_in    = first_ff;
      acc_in      = acc_ff;
      done_in     = 1'b0;
      if (prod_vld_ff) begin
         acc_in   = (first_ff ? '0 : (acc_ff << CHUNK_W)) + ACC_W'(prod_ff);
         first_in = 1'b0;
         done_in  = (left_ff == '0);
      end
      if (ctl.start) begin
         op_in    = operand;
         mult_in  = mult;
         left_in  = ctl.chunks;
         first_in = 1'b1;
      end else if (left_ff != '0) begin
         prod_in     = PROD_W'(op_ff[OP_W-1 -: CHUNK_W]) * PROD_W'(mult_ff);
         op_in       = op_ff << CHUNK_W;
         left_in     = left_ff - 1'b1;
         prod_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff     <= '0;
         prod_vld_ff <= 1'b0;
         first_ff    <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         left_ff     <= left_in;
         prod_vld_ff <= prod_vld_in;
         first_ff    <= first_in;
         done_ff     <= done_in;
      end
      op_ff   <= op_in;
      mult_ff <= mult_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign sts.busy = (left_ff != '0) || prod_vld_ff;
   assign sts.done = done_ff;
   assign acc      = acc_ff;

endmodule

/* design/rbm_bar_mem.sv */
module rbm_bar_mem
   import rbm_pkg::*;
#(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  bar_ctl_type       ctl,
   input  logic [ADDR_W-1:0] rd_addr,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] bar_mem_ff [DEPTH];
   logic [DEPTH-1:0]  valid_ff, valid_in;
   logic [DATA_W-1:0] rd_data_ff;
   logic              rd_vld_ff;

   // Drop every entry on clear, mark an entry on write
   always_comb begin
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = '0;
      end else if (ctl.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (ctl.rd_en) begin
            rd_vld_ff <= valid_ff[rd_addr];
         end
      end
   end

   // Memory write and registered read
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         bar_mem_ff[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= bar_mem_ff[rd_addr];
      end
   end

   // An entry never written since clear reads as zero
   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule
